FILE: sv/aabb_cs_pkg.sv
`default_nettype none

package aabb_cs_pkg;

    localparam int POS_W      = 32;
    localparam int SIZE_W     = 30;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DIR_W      = 3;
    // |own - other| of two 32-bit signed values
    localparam int ABS_W      = POS_W + 1;
    // sum of three 30-bit sizes
    localparam int SUM_W      = SIZE_W + 2;
    // 2*|d| and penetration depth
    localparam int PEN_W      = ABS_W + 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_CENTER_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_CENTER_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_WIDTH        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_HEIGHT       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLLISION_MARGIN = 3'd4;

    localparam logic [DIR_W-1:0] DIR_NONE  = 3'd0;
    localparam logic [DIR_W-1:0] DIR_NORTH = 3'd1;
    localparam logic [DIR_W-1:0] DIR_SOUTH = 3'd2;
    localparam logic [DIR_W-1:0] DIR_EAST  = 3'd3;
    localparam logic [DIR_W-1:0] DIR_WEST  = 3'd4;

    typedef enum logic [1:0] {
        SIDE_NORTH = 2'd0,
        SIDE_SOUTH = 2'd1,
        SIDE_EAST  = 2'd2,
        SIDE_WEST  = 2'd3
    } t_side;

    typedef struct packed {
        logic  hit;
        t_side side;
        logic  frame_end;
    } t_cls;

endpackage

`default_nettype wire

FILE: sv/aabb_cs_ifs.sv
`default_nettype none

interface aabb_in_if import aabb_cs_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  other_x;
    logic signed [POS_W-1:0]  other_y;
    logic        [SIZE_W-1:0] other_width;
    logic        [SIZE_W-1:0] other_height;
    logic                     frame_end;

    modport source (output valid, other_x, other_y, other_width, other_height, frame_end,
                    input ready);
    modport sink   (input valid, other_x, other_y, other_width, other_height, frame_end,
                    output ready);
    modport mon    (input valid, ready, other_x, other_y, other_width, other_height,
                    frame_end);
endinterface

interface aabb_out_if import aabb_cs_pkg::*;;
    logic             valid;
    logic             ready;
    logic             hit;
    logic             any_hit;
    logic             resolved_valid;
    logic [DIR_W-1:0] push_direction;

    modport source (output valid, hit, any_hit, resolved_valid, push_direction,
                    input ready);
    modport sink   (input valid, hit, any_hit, resolved_valid, push_direction,
                    output ready);
    modport mon    (input valid, ready, hit, any_hit, resolved_valid, push_direction);
endinterface

interface aabb_cfg_if import aabb_cs_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
    modport mon    (input valid, ready, index, data);
endinterface

`default_nettype wire

FILE: sv/aabb_cs_front.sv
`default_nettype none

module aabb_cs_front import aabb_cs_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [POS_W-1:0]  i_other_x,
    input  logic signed [POS_W-1:0]  i_other_y,
    input  logic [SIZE_W-1:0]        i_other_width,
    input  logic [SIZE_W-1:0]        i_other_height,
    input  logic                     i_frame_end,
    output logic                     o_push,
    output t_cls                     o_cls,
    input  logic                     i_full
);

    logic [POS_W-1:0]  r_own_x;
    logic [POS_W-1:0]  r_own_y;
    logic [SIZE_W-1:0] r_own_w;
    logic [SIZE_W-1:0] r_own_h;
    logic [SIZE_W-1:0] r_margin;

    logic              r_s1_valid;
    logic [ABS_W-1:0]  r_adx;
    logic [ABS_W-1:0]  r_ady;
    logic [SUM_W-1:0]  r_sx;
    logic [SUM_W-1:0]  r_sy;
    logic              r_dx_pos;
    logic              r_dy_pos;
    logic              r_fe;

    logic [ABS_W-1:0]  x_own, x_oth, y_own, y_oth;
    logic [ABS_W-1:0]  dx_ab, dx_ba, dy_ab, dy_ba;
    logic [ABS_W-1:0]  n_adx, n_ady;
    logic [SUM_W-1:0]  n_sx, n_sy;
    logic              n_dx_pos, n_dy_pos;
    logic              s1_load;

    logic [PEN_W-1:0]  ax2, ay2, sx_w, sy_w, px, py;
    logic              hit, pick_x;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_x  <= '0;
            r_own_y  <= '0;
            r_own_w  <= '0;
            r_own_h  <= '0;
            r_margin <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_OWN_CENTER_X:     r_own_x  <= i_cfg_data;
                CFG_OWN_CENTER_Y:     r_own_y  <= i_cfg_data;
                CFG_OWN_WIDTH:        r_own_w  <= i_cfg_data[SIZE_W-1:0];
                CFG_OWN_HEIGHT:       r_own_h  <= i_cfg_data[SIZE_W-1:0];
                CFG_COLLISION_MARGIN: r_margin <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // both differences in parallel, pick the non-negative one
    always_comb begin
        x_own    = {r_own_x[POS_W-1], r_own_x};
        x_oth    = {i_other_x[POS_W-1], i_other_x};
        y_own    = {r_own_y[POS_W-1], r_own_y};
        y_oth    = {i_other_y[POS_W-1], i_other_y};
        dx_ab    = x_own - x_oth;
        dx_ba    = x_oth - x_own;
        dy_ab    = y_own - y_oth;
        dy_ba    = y_oth - y_own;
        n_adx    = dx_ab[ABS_W-1] ? dx_ba : dx_ab;
        n_ady    = dy_ab[ABS_W-1] ? dy_ba : dy_ab;
        n_dx_pos = !dx_ab[ABS_W-1] && (dx_ab != '0);
        n_dy_pos = !dy_ab[ABS_W-1] && (dy_ab != '0);
        n_sx     = SUM_W'(r_own_w) + SUM_W'(r_margin) + SUM_W'(i_other_width);
        n_sy     = SUM_W'(r_own_h) + SUM_W'(r_margin) + SUM_W'(i_other_height);
    end

    assign o_ready = !r_s1_valid || !i_full;
    assign o_push  = r_s1_valid && !i_full;
    assign s1_load = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_load) begin
            r_s1_valid <= 1'b1;
        end else if (o_push) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_adx    <= n_adx;
            r_ady    <= n_ady;
            r_sx     <= n_sx;
            r_sy     <= n_sy;
            r_dx_pos <= n_dx_pos;
            r_dy_pos <= n_dy_pos;
            r_fe     <= i_frame_end;
        end
    end

    // overlap and shallower-penetration axis; ties go to y
    always_comb begin
        ax2    = {r_adx, 1'b0};
        ay2    = {r_ady, 1'b0};
        sx_w   = PEN_W'(r_sx);
        sy_w   = PEN_W'(r_sy);
        hit    = (ax2 < sx_w) && (ay2 < sy_w);
        px     = sx_w - ax2;
        py     = sy_w - ay2;
        pick_x = px < py;
        o_cls.hit       = hit;
        o_cls.frame_end = r_fe;
        if (pick_x) begin
            o_cls.side = r_dx_pos ? SIDE_WEST : SIDE_EAST;
        end else begin
            o_cls.side = r_dy_pos ? SIDE_NORTH : SIDE_SOUTH;
        end
    end

endmodule

`default_nettype wire

FILE: sv/aabb_cs_queue.sv
`default_nettype none

module aabb_cs_queue import aabb_cs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_cls,
    output logic o_full,
    input  logic i_pop,
    output t_cls o_cls,
    output logic o_empty
);

    t_cls                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_AW:0]   r_cnt;

    assign o_full  = r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_cls   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: sv/aabb_cs_back.sv
`default_nettype none

module aabb_cs_back import aabb_cs_pkg::*; #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  t_cls             i_cls,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_hit,
    output logic             o_any_hit,
    output logic             o_resolved_valid,
    output logic [DIR_W-1:0] o_push_direction
);

    logic [COUNT_WIDTH-1:0] r_cnt [4];
    logic [COUNT_WIDTH-1:0] bumped [4];
    logic                   r_seen;
    logic                   r_out_valid;
    logic                   r_hit;
    logic                   r_any;
    logic                   r_rv;
    logic [DIR_W-1:0]       r_dir;

    logic [COUNT_WIDTH-1:0] cn, cs, ce, cw;
    logic                   n, s, e, w;
    logic [DIR_W-1:0]       dir;
    logic                   n_any;

    assign o_pop = !i_empty && (!r_out_valid || i_ready);

    // saturating count of the contact side
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            bumped[k] = r_cnt[k] + COUNT_WIDTH'(i_cls.hit && (i_cls.side == t_side'(2'(k)))
                                                && !(&r_cnt[k]));
        end
    end

    always_comb begin
        cn = bumped[SIDE_NORTH];
        cs = bumped[SIDE_SOUTH];
        ce = bumped[SIDE_EAST];
        cw = bumped[SIDE_WEST];
        n  = cn != '0;
        s  = cs != '0;
        e  = ce != '0;
        w  = cw != '0;
        dir = DIR_NONE;
        if (n || s) begin
            if (w && !e) begin
                dir = DIR_EAST;
            end else if (e && !w) begin
                dir = DIR_WEST;
            end else if (!n) begin
                dir = DIR_NORTH;
            end else if (!s) begin
                dir = DIR_SOUTH;
            end else if (cn > cs) begin
                dir = DIR_SOUTH;
            end else if (cs > cn) begin
                dir = DIR_NORTH;
            end
        end else if (w) begin
            if (!e) begin
                dir = DIR_EAST;
            end else if (ce > cw) begin
                dir = DIR_WEST;
            end else if (cw > ce) begin
                dir = DIR_EAST;
            end
        end else if (e) begin
            dir = DIR_WEST;
        end
        n_any = r_seen || i_cls.hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_cnt[k] <= '0;
            end
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            for (int k = 0; k < 4; k++) begin
                r_cnt[k] <= i_cls.frame_end ? '0 : bumped[k];
            end
            r_seen      <= i_cls.frame_end ? 1'b0 : n_any;
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_hit <= i_cls.hit;
            r_any <= n_any;
            r_rv  <= i_cls.frame_end;
            r_dir <= i_cls.frame_end ? dir : DIR_NONE;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_hit            = r_hit;
    assign o_any_hit        = r_any;
    assign o_resolved_valid = r_rv;
    assign o_push_direction = r_dir;

endmodule

`default_nettype wire

FILE: sv/aabb_collision_side_resolver_core.sv
// channel | dir | handshake      | payload
// i_cfg   | in  | valid / ready  | index (3b), data (32b); ready always high
// i_in    | in  | valid / ready  | other_x, other_y, other_width, other_height, frame_end
// o_out   | out | valid / ready  | hit, any_hit, resolved_valid, push_direction
//
// one box per cycle while o_out is not stalled; a result passes the geometry register, the queue and
// the output register in that order before it is offered on o_out
// i_rst_n is synchronous active low, clears the config registers, side counters and valid flags and empties the queue
// a stalled output fills the queue and then the geometry stage before i_in.ready drops
`default_nettype none

module aabb_collision_side_resolver_core import aabb_cs_pkg::*; #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    aabb_cfg_if.sink          i_cfg,
    aabb_in_if.sink           i_in,
    aabb_out_if.source        o_out
);

    // front to queue
    logic push;
    logic full;
    t_cls front_cls;

    // queue to back
    logic pop;
    logic empty;
    t_cls head_cls;

    // front: config registers, differences and sums, then overlap and side classify
    aabb_cs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg.valid),
        .o_cfg_ready    (i_cfg.ready),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_valid        (i_in.valid),
        .o_ready        (i_in.ready),
        .i_other_x      (i_in.other_x),
        .i_other_y      (i_in.other_y),
        .i_other_width  (i_in.other_width),
        .i_other_height (i_in.other_height),
        .i_frame_end    (i_in.frame_end),
        .o_push         (push),
        .o_cls          (front_cls),
        .i_full         (full)
    );

    // short queue of classified boxes, decouples the two sides
    aabb_cs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cls   (front_cls),
        .o_full  (full),
        .i_pop   (pop),
        .o_cls   (head_cls),
        .o_empty (empty)
    );

    // back: side counters, frame resolve and output register
    aabb_cs_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_empty          (empty),
        .i_cls            (head_cls),
        .o_pop            (pop),
        .o_valid          (o_out.valid),
        .i_ready          (o_out.ready),
        .o_hit            (o_out.hit),
        .o_any_hit        (o_out.any_hit),
        .o_resolved_valid (o_out.resolved_valid),
        .o_push_direction (o_out.push_direction)
    );

endmodule

`default_nettype wire

FILE: sv/aabb_cs_checker.sv
`default_nettype none

module aabb_cs_checker import aabb_cs_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             i_ready,
    input logic             i_hit,
    input logic             i_any_hit,
    input logic             i_resolved_valid,
    input logic [DIR_W-1:0] i_push_direction
);

    logic xfer;
    logic r_after_end;
    logic r_any_open;

    assign xfer = i_valid && i_ready;

    // frame tracking as seen on the result stream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_end <= 1'b1;
            r_any_open  <= 1'b0;
        end else if (xfer) begin
            r_after_end <= i_resolved_valid;
            r_any_open  <= i_any_hit && !i_resolved_valid;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_hit)
            && $stable(i_any_hit) && $stable(i_resolved_valid)
            && $stable(i_push_direction))
        else $error("result changed while stalled");

    a_dir_only_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_resolved_valid |-> i_push_direction == DIR_NONE)
        else $error("push direction outside frame end");

    a_new_frame_any: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && r_after_end |-> i_any_hit == i_hit)
        else $error("hit flag not cleared at frame end");

    a_any_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && r_any_open |-> i_any_hit)
        else $error("any_hit dropped within a frame");

endmodule

bind aabb_collision_side_resolver_core aabb_cs_checker u_aabb_cs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (o_out.valid),
    .i_ready          (o_out.ready),
    .i_hit            (o_out.hit),
    .i_any_hit        (o_out.any_hit),
    .i_resolved_valid (o_out.resolved_valid),
    .i_push_direction (o_out.push_direction)
);

`default_nettype wire
